/* hdl/fbblit_pkg.sv */
// Shared types, constants and the walk-position settle function for the
// framebuffer blitter. No dependencies; every other file imports this package.
package fbblit_pkg;

    // Framebuffer geometry and the transparent palette index
    localparam int unsigned LINE_WIDTH  = 320;
    localparam int unsigned FRAME_ROWS  = 200;
    localparam int unsigned KEY_COLOUR  = 199;
    localparam int unsigned FRAME_BYTES = LINE_WIDTH * FRAME_ROWS;

    // Configuration register indexes
    localparam logic [2:0] REG_DEST_COLUMN = 3'd0;
    localparam logic [2:0] REG_DEST_ROW    = 3'd1;
    localparam logic [2:0] REG_AREA_WIDTH  = 3'd2;
    localparam logic [2:0] REG_AREA_HEIGHT = 3'd3;
    localparam logic [2:0] REG_FILL_COLOUR = 3'd4;
    localparam logic [2:0] REG_DRAW_MODE   = 3'd5;

    // Drawing modes
    localparam logic [2:0] MODE_FILL    = 3'd0;
    localparam logic [2:0] MODE_STIPPLE = 3'd1;
    localparam logic [2:0] MODE_OUTLINE = 3'd2;
    localparam logic [2:0] MODE_COPY    = 3'd3;
    localparam logic [2:0] MODE_KEYED   = 3'd4;

    // Commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // Outline phases
    localparam logic [1:0] PH_TOP    = 2'd0;
    localparam logic [1:0] PH_SIDES  = 2'd1;
    localparam logic [1:0] PH_BOTTOM = 2'd2;
    localparam logic [1:0] PH_END    = 2'd3;

    typedef struct packed {
        logic [8:0] dest_column;
        logic [7:0] dest_row;
        logic [8:0] area_width;
        logic [7:0] area_height;
        logic [7:0] fill_colour;
        logic [2:0] draw_mode;
    } blit_cfg_t;

    typedef struct packed {
        logic       command;
        logic [7:0] source_pixel;
    } blit_item_t;

    typedef struct packed {
        logic        write_enable;
        logic [15:0] write_address;
        logic [7:0]  write_pixel;
        logic        done_res;
    } blit_result_t;

    typedef struct packed {
        logic [8:0] column_count;
        logic [7:0] row_count;
        logic [1:0] outline_phase;
        logic       side_select;
    } walk_pos_t;

    typedef struct packed {
        walk_pos_t pos;
        logic      ok;
    } walk_settle_t;

    // Move a position onto the next pixel of the walk; ok is low when none is left.
    function automatic walk_settle_t walk_settle(input blit_cfg_t c, input walk_pos_t p);
        walk_settle_t s;
        logic [7:0]   h;
        logic [8:0]   row_sum;
        s.pos   = p;
        s.ok    = 1'b0;
        row_sum = {1'b0, c.dest_row} + {1'b0, c.area_height};
        // copy modes clip the height at the bottom of the frame
        if ((c.draw_mode == MODE_COPY) || (c.draw_mode == MODE_KEYED)) begin
            if (row_sum >= 9'(FRAME_ROWS))
                h = (c.dest_row >= 8'(FRAME_ROWS)) ? 8'd0 : (8'(FRAME_ROWS) - c.dest_row);
            else
                h = c.area_height;
        end
        else begin
            h = c.area_height;
        end
        if ((c.draw_mode == MODE_FILL) || (c.draw_mode == MODE_STIPPLE) ||
            (c.draw_mode == MODE_COPY) || (c.draw_mode == MODE_KEYED)) begin
            if ((c.area_width != 9'd0) && (s.pos.row_count < h)) begin
                if (s.pos.column_count >= c.area_width) begin
                    s.pos.column_count = 9'd0;
                    s.pos.row_count    = s.pos.row_count + 8'd1;
                    s.ok               = (s.pos.row_count < h);
                end
                else begin
                    s.ok = 1'b1;
                end
            end
        end
        else if (c.draw_mode == MODE_OUTLINE) begin
            if (s.pos.outline_phase == PH_TOP) begin
                if (s.pos.column_count < c.area_width) begin
                    s.ok = 1'b1;
                end
                else begin
                    s.pos.outline_phase = PH_SIDES;
                    s.pos.row_count     = 8'd0;
                    s.pos.side_select   = 1'b0;
                    s.pos.column_count  = 9'd0;
                end
            end
            if (!s.ok && (s.pos.outline_phase == PH_SIDES)) begin
                if (s.pos.row_count < c.area_height) begin
                    s.ok = 1'b1;
                end
                else begin
                    s.pos.outline_phase = PH_BOTTOM;
                    s.pos.column_count  = 9'd0;
                end
            end
            if (!s.ok && (s.pos.outline_phase == PH_BOTTOM)) begin
                if (s.pos.column_count < c.area_width)
                    s.ok = 1'b1;
                else
                    s.pos.outline_phase = PH_END;
            end
        end
        return s;
    endfunction

endpackage

/* hdl/fbblit_regs.sv */
// Configuration register file of the framebuffer blitter.
// Depends on fbblit_pkg for the register indexes and the config struct.
module fbblit_regs (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [8:0]            cfg_data,
    output fbblit_pkg::blit_cfg_t cfg
);
    import fbblit_pkg::*;

    blit_cfg_t cfg_reg;
    blit_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DEST_COLUMN: cfg_next.dest_column = cfg_data;
                REG_DEST_ROW:    cfg_next.dest_row    = cfg_data[7:0];
                REG_AREA_WIDTH:  cfg_next.area_width  = cfg_data;
                REG_AREA_HEIGHT: cfg_next.area_height = cfg_data[7:0];
                REG_FILL_COLOUR: cfg_next.fill_colour = cfg_data[7:0];
                REG_DRAW_MODE:   cfg_next.draw_mode   = cfg_data[2:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

endmodule

/* hdl/fbblit_walk.sv */
// Walk position state and the single-pass step logic of the blitter.
// Depends on fbblit_pkg for types, constants and walk_settle.
module fbblit_walk (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step_en,
    input  fbblit_pkg::blit_item_t   item,
    input  fbblit_pkg::blit_cfg_t    cfg,
    output fbblit_pkg::blit_result_t result
);
    import fbblit_pkg::*;

    walk_pos_t    pos_reg;
    walk_pos_t    pos_next;
    logic         finished_reg;
    logic         finished_next;
    walk_settle_t pre;
    walk_settle_t post;
    walk_pos_t    mid;
    logic [9:0]   col_pos;
    logic [8:0]   row_pos;
    logic [7:0]   pix;
    logic         en;

    always_comb
    begin
        pos_next      = pos_reg;
        finished_next = finished_reg;
        result        = '0;
        pre           = walk_settle(cfg, pos_reg);
        mid           = pre.pos;
        col_pos       = '0;
        row_pos       = '0;
        pix           = '0;
        en            = 1'b0;
        post          = '0;
        if (item.command == CMD_START)
        begin
            pos_next      = '0;
            finished_next = 1'b0;
        end
        else if (finished_reg || !pre.ok)
        begin
            // an idle step only settles the position of an unfinished walk
            if (!finished_reg)
                pos_next = pre.pos;
            finished_next   = 1'b1;
            result.done_res = 1'b1;
        end
        else
        begin
            if (cfg.draw_mode == MODE_OUTLINE)
            begin
                case (mid.outline_phase)
                    PH_TOP:
                    begin
                        col_pos = {1'b0, cfg.dest_column} + {1'b0, mid.column_count};
                        row_pos = {1'b0, cfg.dest_row};
                    end
                    PH_SIDES:
                    begin
                        col_pos = {1'b0, cfg.dest_column}
                                + (mid.side_select ? {1'b0, cfg.area_width} : 10'd0);
                        row_pos = {1'b0, cfg.dest_row} + {1'b0, mid.row_count};
                    end
                    default:
                    begin
                        col_pos = {1'b0, cfg.dest_column} + {1'b0, mid.column_count};
                        row_pos = {1'b0, cfg.dest_row} + {1'b0, cfg.area_height};
                    end
                endcase
                pix = cfg.fill_colour;
                en  = (cfg.fill_colour != 8'(KEY_COLOUR));
                if (mid.outline_phase == PH_SIDES)
                begin
                    if (mid.side_select)
                    begin
                        mid.side_select = 1'b0;
                        mid.row_count   = mid.row_count + 8'd1;
                    end
                    else
                    begin
                        mid.side_select = 1'b1;
                    end
                end
                else
                begin
                    mid.column_count = mid.column_count + 9'd1;
                end
            end
            else
            begin
                col_pos = {1'b0, cfg.dest_column} + {1'b0, mid.column_count};
                row_pos = {1'b0, cfg.dest_row} + {1'b0, mid.row_count};
                if ((cfg.draw_mode == MODE_COPY) || (cfg.draw_mode == MODE_KEYED))
                begin
                    pix = item.source_pixel;
                    en  = (cfg.draw_mode == MODE_COPY) ||
                          (item.source_pixel != 8'(KEY_COLOUR));
                end
                else
                begin
                    pix = cfg.fill_colour;
                    en  = (cfg.fill_colour != 8'(KEY_COLOUR));
                    // stipple: write only where column plus row is odd
                    if ((cfg.draw_mode == MODE_STIPPLE) &&
                        ((mid.column_count[0] ^ mid.row_count[0]) == 1'b0))
                        en = 1'b0;
                end
                mid.column_count = mid.column_count + 9'd1;
                if (mid.column_count >= cfg.area_width)
                begin
                    mid.column_count = 9'd0;
                    mid.row_count    = mid.row_count + 8'd1;
                end
            end
            // drop pixels that fall off the frame
            if ((col_pos >= 10'(LINE_WIDTH)) || (row_pos >= 9'(FRAME_ROWS)))
                en = 1'b0;
            post          = walk_settle(cfg, mid);
            pos_next      = post.pos;
            finished_next = !post.ok;
            result.write_enable  = en;
            result.write_address = en ? (16'(row_pos) * 16'(LINE_WIDTH) + 16'(col_pos))
                                      : 16'd0;
            result.write_pixel   = en ? pix : 8'd0;
            result.done_res      = !post.ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            finished_reg <= 1'b1;
        end
        else if (step_en)
        begin
            pos_reg      <= pos_next;
            finished_reg <= finished_next;
        end
    end

endmodule

/* hdl/framebuffer_blitter.sv */
// Framebuffer blitter top level: input register, walk step, result register.
// Path: an accepted item waits in the input register; its step result is
// loaded into the result register when that register is free or emptying.
// Throughput: one item per cycle unless the result channel stalls; the step
// logic runs in a single pass between the input and result registers.
// Reset: walk position zero, walker idle, config zero, pipeline empty.
module framebuffer_blitter (
    input  logic                     clk,
    input  logic                     rst_n,
    // item channel
    input  logic                     item_valid,
    output logic                     item_ready,
    input  fbblit_pkg::blit_item_t   item,
    // result channel
    output logic                     result_valid,
    input  logic                     result_ready,
    output fbblit_pkg::blit_result_t result,
    // configuration write channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [2:0]               cfg_index,
    input  logic [8:0]               cfg_data
);
    import fbblit_pkg::*;

    // Input register: holds one accepted item until the step logic takes it.
    logic         stage_valid_reg;
    logic         stage_valid_next;
    blit_item_t   stage_item_reg;
    // Result register: holds the step result until the result transfer.
    logic         result_valid_reg;
    logic         result_valid_next;
    blit_result_t result_reg;

    blit_cfg_t    cfg;
    blit_result_t step_result;
    logic         advance;

    // Configuration registers; writes are taken every cycle.
    fbblit_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Walker: the position state moves only when the held item advances.
    fbblit_walk u_walk (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (stage_item_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    // Advance the held item when the result register is free or being emptied.
    assign advance    = stage_valid_reg && (!result_valid_reg || result_ready);
    // Take a new item when the input register is empty or moving on.
    assign item_ready = !stage_valid_reg || advance;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (item_valid && item_ready)
            stage_valid_next = 1'b1;
        else if (advance)
            stage_valid_next = 1'b0;

        result_valid_next = result_valid_reg;
        if (advance)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers: load on transfer, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            stage_item_reg <= item;
        if (advance)
            result_reg <= step_result;
    end

`ifndef SYNTHESIS
    // A written pixel always lands inside the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.write_enable |-> result.write_address < 16'(FRAME_BYTES))
        else $error("write address beyond frame");

    // A slot without a write carries zero address and pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.write_enable |->
            (result.write_address == 16'd0) && (result.write_pixel == 8'd0))
        else $error("disabled slot carries data");

    // A start command yields an empty, not-done slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && (stage_item_reg.command == CMD_START) |=>
            result_valid && !result.write_enable && !result.done_res)
        else $error("start result not empty");

    // A result still waiting keeps the held item from advancing.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_ready |-> !advance)
        else $error("item advanced over a stalled result");
`endif

endmodule

/* verif/framebuffer_blitter_tb.sv */
// Self-checking testbench for framebuffer_blitter: directed and random blit
// operations, predicted write slots checked field by field on every transfer.
// Depends on fbblit_pkg and the framebuffer_blitter RTL only.
`timescale 1ns / 100ps

module framebuffer_blitter_tb;
    import fbblit_pkg::*;

    localparam int unsigned RANDOM_ITEMS  = 1900;
    localparam int unsigned HOLD_SPAN     = 300;   // long receiver hold-off
    localparam int unsigned QUIET_LIMIT   = 3000;  // cycles without any transfer
    localparam int unsigned DRAIN_CYCLES  = 4;     // drains the input and result registers, plus margin
    localparam int unsigned SPARE_MODE_LO = 5;
    localparam int unsigned SPARE_MODE_HI = 7;

    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         item_valid   = 1'b0;
    logic         item_ready;
    blit_item_t   item         = '0;
    logic         result_valid;
    logic         result_ready = 1'b0;
    blit_result_t result;
    logic         cfg_valid    = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index    = REG_DEST_COLUMN;
    logic [8:0]   cfg_data     = '0;

    // Shadow of the register file and of the walk position
    blit_cfg_t    shadow_cfg   = '0;
    logic [8:0]   walk_col     = '0;
    logic [7:0]   walk_row     = '0;
    logic [1:0]   walk_stage   = PH_TOP;
    logic         walk_right   = 1'b0;
    logic         walk_idle    = 1'b1;

    blit_item_t   item_backlog[$];     // items waiting for the driver
    blit_result_t expected_slots[$];   // predicted write slots, oldest first

    int unsigned  queued_items  = 0;
    int unsigned  checked_items = 0;
    int unsigned  error_count   = 0;
    int unsigned  send_idle_pct = 0;
    int unsigned  stall_pct     = 0;
    logic         hold_armed    = 1'b0;
    int unsigned  hold_elapsed  = 0;
    int unsigned  quiet_cycles  = 0;

    framebuffer_blitter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Rows actually walked: the copy modes clip at the bottom of the frame.
    function automatic int unsigned rows_in_walk(input logic [2:0] mode,
                                                 input int unsigned top,
                                                 input int unsigned height);
        if ((mode == MODE_COPY) || (mode == MODE_KEYED))
        begin
            if (top + height >= FRAME_ROWS)
                return (top >= FRAME_ROWS) ? 0 : FRAME_ROWS - top;
        end
        return height;
    endfunction

    // Advance the shadow position onto the next pixel to draw; low when the
    // walk has run out. Always reads the current register values, so a walk
    // that outlives a register change wraps onto the next row or edge.
    function automatic bit seek_pixel();
        int unsigned w;
        int unsigned h;
        w = 32'(shadow_cfg.area_width);
        h = rows_in_walk(shadow_cfg.draw_mode, 32'(shadow_cfg.dest_row),
                         32'(shadow_cfg.area_height));
        case (shadow_cfg.draw_mode)
            MODE_FILL, MODE_STIPPLE, MODE_COPY, MODE_KEYED:
            begin
                if ((w == 0) || (32'(walk_row) >= h))
                    return 1'b0;
                if (32'(walk_col) >= w)
                begin
                    walk_col = '0;
                    walk_row = walk_row + 8'd1;
                    return 32'(walk_row) < h;
                end
                return 1'b1;
            end
            MODE_OUTLINE:
            begin
                // skip any empty edge and fall through to the next one
                if (walk_stage == PH_TOP)
                begin
                    if (32'(walk_col) < w)
                        return 1'b1;
                    walk_stage = PH_SIDES;
                    walk_row   = '0;
                    walk_right = 1'b0;
                    walk_col   = '0;
                end
                if (walk_stage == PH_SIDES)
                begin
                    if (walk_row < shadow_cfg.area_height)
                        return 1'b1;
                    walk_stage = PH_BOTTOM;
                    walk_col   = '0;
                end
                if (walk_stage == PH_BOTTOM)
                begin
                    if (32'(walk_col) < w)
                        return 1'b1;
                    walk_stage = PH_END;
                end
                return 1'b0;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // Work out the write slot that one accepted item produces.
    function automatic blit_result_t next_write_slot(input blit_item_t it);
        blit_result_t slot;
        int unsigned  x;
        int unsigned  y;
        logic [7:0]   colour;
        logic         writes;
        slot = '0;
        if (it.command == CMD_START)
        begin
            walk_col   = '0;
            walk_row   = '0;
            walk_stage = PH_TOP;
            walk_right = 1'b0;
            walk_idle  = 1'b0;
            return slot;
        end
        // idle advance, empty area or spare mode: nothing drawn, done held high
        if (walk_idle || !seek_pixel())
        begin
            walk_idle     = 1'b1;
            slot.done_res = 1'b1;
            return slot;
        end
        if (shadow_cfg.draw_mode == MODE_OUTLINE)
        begin
            colour = shadow_cfg.fill_colour;
            writes = (colour != 8'(KEY_COLOUR));
            case (walk_stage)
                PH_TOP:
                begin
                    x = 32'(shadow_cfg.dest_column) + 32'(walk_col);
                    y = 32'(shadow_cfg.dest_row);
                end
                PH_SIDES:
                begin
                    // right edge sits one past the width
                    x = 32'(shadow_cfg.dest_column) +
                        (walk_right ? 32'(shadow_cfg.area_width) : 0);
                    y = 32'(shadow_cfg.dest_row) + 32'(walk_row);
                end
                default:
                begin
                    x = 32'(shadow_cfg.dest_column) + 32'(walk_col);
                    y = 32'(shadow_cfg.dest_row) + 32'(shadow_cfg.area_height);
                end
            endcase
            if (walk_stage == PH_SIDES)
            begin
                if (walk_right)
                begin
                    walk_right = 1'b0;
                    walk_row   = walk_row + 8'd1;
                end
                else
                begin
                    walk_right = 1'b1;
                end
            end
            else
            begin
                walk_col = walk_col + 9'd1;
            end
        end
        else
        begin
            x = 32'(shadow_cfg.dest_column) + 32'(walk_col);
            y = 32'(shadow_cfg.dest_row) + 32'(walk_row);
            if ((shadow_cfg.draw_mode == MODE_COPY) || (shadow_cfg.draw_mode == MODE_KEYED))
            begin
                colour = it.source_pixel;
                writes = (shadow_cfg.draw_mode == MODE_COPY) || (colour != 8'(KEY_COLOUR));
            end
            else
            begin
                colour = shadow_cfg.fill_colour;
                writes = (colour != 8'(KEY_COLOUR));
                // stipple draws only where column plus row offset is odd
                if ((shadow_cfg.draw_mode == MODE_STIPPLE) && !(walk_col[0] ^ walk_row[0]))
                    writes = 1'b0;
            end
            walk_col = walk_col + 9'd1;
            if (walk_col >= shadow_cfg.area_width)
            begin
                walk_col = '0;
                walk_row = walk_row + 8'd1;
            end
        end
        // drop anything that lands off the frame
        if ((x >= LINE_WIDTH) || (y >= FRAME_ROWS))
            writes = 1'b0;
        if (!seek_pixel())
            walk_idle = 1'b1;
        slot.write_enable = writes;
        if (writes)
        begin
            slot.write_address = 16'(y * LINE_WIDTH + x);
            slot.write_pixel   = colour;
        end
        slot.done_res = walk_idle;
        return slot;
    endfunction

    // Steps needed to finish a walk from its start.
    function automatic int unsigned walk_length(input logic [2:0] mode,
                                                input int unsigned top,
                                                input int unsigned w,
                                                input int unsigned h);
        case (mode)
            MODE_FILL, MODE_STIPPLE: return w * h;
            MODE_OUTLINE:            return 2 * w + 2 * h;
            MODE_COPY, MODE_KEYED:   return w * rows_in_walk(mode, top, h);
            default:                 return 1;
        endcase
    endfunction

    function automatic void push_item(input logic command, input logic [7:0] pixel);
        blit_item_t it;
        it.command      = command;
        it.source_pixel = pixel;
        item_backlog.push_back(it);
        queued_items++;
    endfunction

    // Queue advance commands; in the copy modes one source pixel in four is the key.
    function automatic void push_steps(input int unsigned count, input logic [2:0] mode);
        logic [7:0] pixel;
        for (int unsigned i = 0; i < count; i++)
        begin
            pixel = 8'($urandom_range(0, 255));
            if (((mode == MODE_COPY) || (mode == MODE_KEYED)) && ($urandom_range(0, 3) == 0))
                pixel = 8'(KEY_COLOUR);
            push_item(CMD_STEP, pixel);
        end
    endfunction

    // One register transfer; the shadow follows at the accepting edge.
    task automatic write_reg(input logic [2:0] index, input logic [8:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (index)
            REG_DEST_COLUMN: shadow_cfg.dest_column = data;
            REG_DEST_ROW:    shadow_cfg.dest_row    = data[7:0];
            REG_AREA_WIDTH:  shadow_cfg.area_width  = data;
            REG_AREA_HEIGHT: shadow_cfg.area_height = data[7:0];
            REG_FILL_COLOUR: shadow_cfg.fill_colour = data[7:0];
            REG_DRAW_MODE:   shadow_cfg.draw_mode   = data[2:0];
            default: ;
        endcase
    endtask

    task automatic program_area(input int unsigned left, input int unsigned top,
                                input int unsigned w, input int unsigned h,
                                input int unsigned colour, input logic [2:0] mode);
        write_reg(REG_DEST_COLUMN, 9'(left));
        write_reg(REG_DEST_ROW,    9'(top));
        write_reg(REG_AREA_WIDTH,  9'(w));
        write_reg(REG_AREA_HEIGHT, 9'(h));
        write_reg(REG_FILL_COLOUR, 9'(colour));
        write_reg(REG_DRAW_MODE,   9'(mode));
    endtask

    // Hold until every queued item has come back as a checked slot, then let
    // the pipeline run dry before the registers are touched.
    task automatic settle_idle();
        while ((item_backlog.size() != 0) || (checked_items < queued_items))
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Item driver: predict on each transfer, then offer the next item unless
    // the sender idles this cycle. Valid is held with the payload until taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else
        begin
            if (item_valid && item_ready)
                expected_slots.push_back(next_write_slot(item));
            if (!item_valid || item_ready)
            begin
                if ((item_backlog.size() != 0) && ($urandom_range(0, 99) >= send_idle_pct))
                begin
                    item_valid <= 1'b1;
                    item       <= item_backlog.pop_front();
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each transfer against the oldest prediction and
    // choose ready for the next cycle. Once armed, hold ready low for a long
    // stretch so the block backs up and stalls its input.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        blit_result_t want;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                checked_items = checked_items + 1;
                if (expected_slots.size() == 0)
                begin
                    $error("write slot transfer with no prediction waiting");
                    error_count = error_count + 1;
                end
                else
                begin
                    want = expected_slots.pop_front();
                    if (result.write_enable !== want.write_enable)
                    begin
                        $error("write_enable: expected %0d, got %0d",
                               want.write_enable, result.write_enable);
                        error_count = error_count + 1;
                    end
                    if (result.write_address !== want.write_address)
                    begin
                        $error("write_address: expected %0d, got %0d",
                               want.write_address, result.write_address);
                        error_count = error_count + 1;
                    end
                    if (result.write_pixel !== want.write_pixel)
                    begin
                        $error("write_pixel: expected %0d, got %0d",
                               want.write_pixel, result.write_pixel);
                        error_count = error_count + 1;
                    end
                    if (result.done_res !== want.done_res)
                    begin
                        $error("done_res: expected %0d, got %0d",
                               want.done_res, result.done_res);
                        error_count = error_count + 1;
                    end
                end
            end
            if (hold_armed && (hold_elapsed < HOLD_SPAN))
            begin
                result_ready <= 1'b0;
                hold_elapsed <= hold_elapsed + 1;
            end
            else
            begin
                result_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Watchdog: end the run once no channel has moved a transfer for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("framebuffer_blitter regression: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int unsigned base;
        int unsigned phase;
        int unsigned pick;
        int unsigned left;
        int unsigned top;
        int unsigned w;
        int unsigned h;
        int unsigned colour;
        int unsigned len;
        logic [2:0]  mode;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        settle_idle();

        // Directed: advance with the walker idle straight out of reset,
        // then an empty area with all registers still zero
        push_item(CMD_STEP, 8'h00);
        push_item(CMD_START, 8'hFF);
        push_item(CMD_STEP, 8'hFF);
        settle_idle();

        // fill in the bottom-right corner: three of four pixels fall off the frame
        program_area(319, 199, 2, 2, 0, MODE_FILL);
        push_item(CMD_START, 8'h00);
        push_steps(4, MODE_FILL);
        settle_idle();

        program_area(0, 0, 2, 2, 255, MODE_STIPPLE);
        push_item(CMD_START, 8'h00);
        push_steps(4, MODE_STIPPLE);
        settle_idle();

        // outline in the key colour walks every edge but draws nothing
        program_area(5, 5, 1, 1, KEY_COLOUR, MODE_OUTLINE);
        push_item(CMD_START, 8'h00);
        push_steps(4, MODE_OUTLINE);
        settle_idle();

        // copy starting below the frame clips to zero rows
        program_area(10, 220, 3, 2, 1, MODE_COPY);
        push_item(CMD_START, 8'h00);
        push_steps(1, MODE_COPY);
        settle_idle();

        // keyed copy clipped to two rows, key pixels skipped
        program_area(10, 198, 2, 5, 2, MODE_KEYED);
        push_item(CMD_START, 8'h00);
        push_item(CMD_STEP, 8'(KEY_COLOUR));
        push_item(CMD_STEP, 8'h07);
        push_item(CMD_STEP, 8'(KEY_COLOUR));
        push_item(CMD_STEP, 8'hFF);
        settle_idle();

        program_area(0, 0, 4, 4, 3, 3'(SPARE_MODE_HI));
        push_item(CMD_START, 8'h00);
        push_steps(1, MODE_FILL);
        settle_idle();

        // Random part. Open with the long receiver hold-off while the sender
        // keeps offering a full 8x8 fill.
        base          = queued_items;
        send_idle_pct = 0;
        stall_pct     = 0;
        program_area(40, 20, 8, 8, 32'h55, MODE_FILL);
        hold_armed <= 1'b1;
        push_item(CMD_START, 8'h00);
        push_steps(64, MODE_FILL);

        while (queued_items - base < RANDOM_ITEMS)
        begin
            settle_idle();
            // idling phases: none, sender idle, receiver stalling, both lightly
            phase = (queued_items - base) * 4 / RANDOM_ITEMS;
            case (phase)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 80; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 80; end
                default: begin send_idle_pct = 15; stall_pct = 15; end
            endcase

            pick = $urandom_range(0, 19);
            if (pick < 4)
                mode = MODE_FILL;
            else if (pick < 8)
                mode = MODE_STIPPLE;
            else if (pick < 12)
                mode = MODE_OUTLINE;
            else if (pick < 15)
                mode = MODE_COPY;
            else if (pick < 19)
                mode = MODE_KEYED;
            else
                mode = 3'($urandom_range(SPARE_MODE_LO, SPARE_MODE_HI));

            // bias the origin towards the right and bottom edges
            left = $urandom_range(0, 1) ? $urandom_range(300, 319) : $urandom_range(0, 319);
            pick = $urandom_range(0, 9);
            if (pick < 4)
                top = $urandom_range(190, 199);
            else if (pick < 9)
                top = $urandom_range(0, 199);
            else
                top = $urandom_range(200, 255);
            colour = ($urandom_range(0, 4) == 0) ? KEY_COLOUR : $urandom_range(0, 255);

            // mostly small areas; now and then a full-width or full-height one
            if ($urandom_range(0, 39) == 0)
            begin
                left = 0;
                top  = 0;
                case ($urandom_range(0, 3))
                    0:       begin w = LINE_WIDTH; h = 1;          end
                    1:       begin w = 1;          h = FRAME_ROWS; end
                    2:       begin w = 0;          h = FRAME_ROWS; end
                    default: begin w = LINE_WIDTH; h = 0;          end
                endcase
            end
            else
            begin
                w = $urandom_range(0, 8);
                h = $urandom_range(0, 5);
            end
            program_area(left, top, w, h, colour, mode);

            // now and then skip the start so the old walk carries on under the
            // new registers; now and then cut the walk short
            if ($urandom_range(0, 9) != 0)
                push_item(CMD_START, 8'($urandom_range(0, 255)));
            len = walk_length(mode, top, w, h) + $urandom_range(0, 2);
            if ($urandom_range(0, 4) == 0)
                len = $urandom_range(0, len);
            push_steps(len, mode);
        end

        settle_idle();
        if (error_count == 0)
            $display("framebuffer_blitter regression: pass");
        else
            $display("framebuffer_blitter regression: fail");
        $finish;
    end

endmodule
